### src/stpfs_pkg.sv
`timescale 1ns / 1ps
// Shared constants and lookup functions for the stepper full-step command driver.
package stpfs_pkg;

    localparam int unsigned RX_BYTE_W = 8;
    localparam int unsigned COIL_W    = 4;
    localparam int unsigned DELAY_W   = 8;
    localparam int unsigned PHASE_W   = 2;
    localparam int unsigned OUT_W     = 8;

    localparam logic [RX_BYTE_W-1:0] CMD_ANTICLOCKWISE = 8'h63;
    localparam logic [RX_BYTE_W-1:0] CMD_CLOCKWISE     = 8'h64;
    localparam logic [RX_BYTE_W-1:0] CMD_STOP          = 8'h30;
    localparam logic [RX_BYTE_W-1:0] CMD_SPEED_FIRST   = 8'd49;
    localparam logic [RX_BYTE_W-1:0] CMD_SPEED_LAST    = 8'd57;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_FIRST = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_LAST  = 2'd3;

    // Step delay in ticks for the speed commands '1' through '9'.
    function automatic logic [DELAY_W-1:0] speed_delay(input logic [3:0] idx);
        logic [DELAY_W-1:0] d;
        begin
            case (idx)
                4'd0:    d = 8'd150;
                4'd1:    d = 8'd100;
                4'd2:    d = 8'd80;
                4'd3:    d = 8'd60;
                4'd4:    d = 8'd50;
                4'd5:    d = 8'd40;
                4'd6:    d = 8'd30;
                4'd7:    d = 8'd20;
                4'd8:    d = 8'd5;
                default: d = 8'd0;
            endcase
            return d;
        end
    endfunction

    // Two-coils-on full-step pattern for a direction and phase.
    function automatic logic [COIL_W-1:0] phase_pattern(input logic acw,
                                                        input logic [PHASE_W-1:0] ph);
        logic [COIL_W-1:0] p;
        begin
            case (ph)
                2'd0:    p = acw ? 4'h9 : 4'h5;
                2'd1:    p = acw ? 4'hA : 4'h6;
                2'd2:    p = acw ? 4'h6 : 4'hA;
                default: p = acw ? 4'h5 : 4'h9;
            endcase
            return p;
        end
    endfunction

    // A zero delay still holds the phase for one tick.
    function automatic logic [DELAY_W-1:0] phase_load(input logic [DELAY_W-1:0] d);
        return (d == '0) ? DELAY_W'(1) : d;
    endfunction

endpackage

### src/stepper_full_step_command_driver.sv
`timescale 1ns / 1ps
// Top level of the stepper full-step command driver.
//
// The input channel carries one request per cycle at most: s_tuser is the kind
// (0 for a received command byte, 1 for a one-millisecond tick) and s_tdata is
// the command byte. Bytes 'c' and 'd' select anticlockwise and clockwise, '0'
// stops, and '1' to '9' start the motor with a step delay from 150 down to 5
// ticks. Every accepted request yields exactly one result request on the
// output channel with the coil pattern, the running flag and the selected
// direction after that request has been applied.
// The result appears in the cycle after acceptance, from the output register.
// Throughput is one request per cycle unless the receiver stalls; the whole
// state update is one pass of logic between state and output registers.
// The input side stays ready while the output register is empty or being
// drained in the same cycle, so a stalled receiver holds one finished result
// and stops further acceptance only until it is taken.
// After reset the motor is halted, clockwise is selected, the coils are off and
// the output register is empty.
module stepper_full_step_command_driver (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       s_tuser,   // [0] kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [3:0] coil_pattern, [4] running, [5] anticlockwise, [7:6] zero
);

    logic                            dir_sel_reg, dir_sel_next;
    logic                            halted_reg, halted_next;
    logic [stpfs_pkg::DELAY_W-1:0]   step_delay_reg, step_delay_next;
    logic                            in_cycle_reg, in_cycle_next;
    logic                            cycle_dir_reg, cycle_dir_next;
    logic [stpfs_pkg::PHASE_W-1:0]   phase_idx_reg, phase_idx_next;
    logic [stpfs_pkg::DELAY_W-1:0]   ticks_left_reg, ticks_left_next;
    logic [stpfs_pkg::COIL_W-1:0]    coils_reg, coils_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [stpfs_pkg::OUT_W-1:0]     m_tdata_reg, m_tdata_next;

    logic                            accept;
    logic [3:0]                      speed_off;
    logic [stpfs_pkg::DELAY_W-1:0]   ticks_dec;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign speed_off = 4'(s_tdata - stpfs_pkg::CMD_SPEED_FIRST);
    assign ticks_dec = (ticks_left_reg != '0) ? ticks_left_reg - 1'b1 : ticks_left_reg;

    always_comb begin
        dir_sel_next    = dir_sel_reg;
        halted_next     = halted_reg;
        step_delay_next = step_delay_reg;
        in_cycle_next   = in_cycle_reg;
        cycle_dir_next  = cycle_dir_reg;
        phase_idx_next  = phase_idx_reg;
        ticks_left_next = ticks_left_reg;
        coils_next      = coils_reg;

        if (s_tuser == stpfs_pkg::KIND_BYTE) begin
            unique case (s_tdata) inside
                stpfs_pkg::CMD_ANTICLOCKWISE: dir_sel_next = 1'b1;
                stpfs_pkg::CMD_CLOCKWISE:     dir_sel_next = 1'b0;
                stpfs_pkg::CMD_STOP:          halted_next  = 1'b1;
                [stpfs_pkg::CMD_SPEED_FIRST:stpfs_pkg::CMD_SPEED_LAST]: begin
                    halted_next     = 1'b0;
                    step_delay_next = stpfs_pkg::speed_delay(speed_off);
                end
                default: ;
            endcase
            if (!in_cycle_reg && !halted_next) begin
                in_cycle_next   = 1'b1;
                cycle_dir_next  = dir_sel_next;
                phase_idx_next  = stpfs_pkg::PHASE_FIRST;
                coils_next      = stpfs_pkg::phase_pattern(dir_sel_next,
                                                           stpfs_pkg::PHASE_FIRST);
                ticks_left_next = stpfs_pkg::phase_load(step_delay_next);
            end
        end else if (in_cycle_reg) begin
            ticks_left_next = ticks_dec;
            if (ticks_dec == '0) begin
                if (phase_idx_reg != stpfs_pkg::PHASE_LAST) begin
                    phase_idx_next  = phase_idx_reg + 1'b1;
                    coils_next      = stpfs_pkg::phase_pattern(cycle_dir_reg,
                                                               phase_idx_reg + 1'b1);
                    ticks_left_next = stpfs_pkg::phase_load(step_delay_reg);
                end else if (!halted_reg) begin
                    cycle_dir_next  = dir_sel_reg;
                    phase_idx_next  = stpfs_pkg::PHASE_FIRST;
                    coils_next      = stpfs_pkg::phase_pattern(dir_sel_reg,
                                                               stpfs_pkg::PHASE_FIRST);
                    ticks_left_next = stpfs_pkg::phase_load(step_delay_reg);
                end else begin
                    in_cycle_next  = 1'b0;
                    phase_idx_next = stpfs_pkg::PHASE_FIRST;
                end
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, dir_sel_next, in_cycle_next, coils_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_sel_reg    <= 1'b0;
            halted_reg     <= 1'b1;
            step_delay_reg <= '0;
            in_cycle_reg   <= 1'b0;
            cycle_dir_reg  <= 1'b0;
            phase_idx_reg  <= stpfs_pkg::PHASE_FIRST;
            ticks_left_reg <= '0;
            coils_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                dir_sel_reg    <= dir_sel_next;
                halted_reg     <= halted_next;
                step_delay_reg <= step_delay_next;
                in_cycle_reg   <= in_cycle_next;
                cycle_dir_reg  <= cycle_dir_next;
                phase_idx_reg  <= phase_idx_next;
                ticks_left_reg <= ticks_left_next;
                coils_reg      <= coils_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

endmodule
